[hw/rtl/esd_pkg.sv]
// shared types, constants and character helpers for the escape sequence decoder
package esd_pkg;

   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned LENGTH_WIDTH = 16;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_ESC    = 8'h1B;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_BS     = 8'h08;
   localparam logic [7:0] CHAR_BEL    = 8'h07;
   localparam logic [7:0] CHAR_LOW_R  = 8'h72;
   localparam logic [7:0] CHAR_LOW_N  = 8'h6E;
   localparam logic [7:0] CHAR_LOW_T  = 8'h74;
   localparam logic [7:0] CHAR_LOW_E  = 8'h65;
   localparam logic [7:0] CHAR_LOW_B  = 8'h62;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_X  = 8'h78;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;

   // hex collection phase
   localparam logic [1:0] HEX_IDLE   = 2'd0;
   localparam logic [1:0] HEX_FIRST  = 2'd1;
   localparam logic [1:0] HEX_SECOND = 2'd2;

   // register word index
   localparam logic REG_ESCAPE_MODE = 1'b0;

   // one classified request: up to two bytes plus an optional end item
   typedef struct packed {
      logic [1:0]              n_bytes;
      logic [BYTE_WIDTH-1:0]   byte0;
      logic [BYTE_WIDTH-1:0]   byte1;
      logic                    is_end;
      logic [LENGTH_WIDTH-1:0] length;
   } cmd_type;

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c inside {8'h20, [8'h09:8'h0D]});
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30;
      end else if (c inside {[8'h61:8'h66]}) begin
         d = c - 8'h57;
      end else if (c inside {[8'h41:8'h46]}) begin
         d = c - 8'h37;
      end
      hex_val = d[3:0];
   endfunction

   // strtol-style parse of two characters, modulo 256
   function automatic logic [7:0] hex_pair(input logic [7:0] c0, input logic [7:0] c1);
      logic [7:0] val;
      logic       neg;
      val = 8'h00;
      neg = 1'b0;
      if (is_space(c0)) begin
         if (!is_space(c1) && is_hex(c1)) begin
            val = {4'h0, hex_val(c1)};
         end
      end else if (c0 == CHAR_PLUS || c0 == CHAR_MINUS) begin
         neg = (c0 == CHAR_MINUS);
         if (is_hex(c1)) begin
            val = {4'h0, hex_val(c1)};
         end
      end else if (is_hex(c0)) begin
         if (is_hex(c1)) begin
            val = {hex_val(c0), hex_val(c1)};
         end else begin
            val = {4'h0, hex_val(c0)};
         end
      end
      hex_pair = neg ? (8'h00 - val) : val;
   endfunction

endpackage

[hw/rtl/esd_front.sv]
// front end: takes request bytes, tracks escape state and classifies them into commands
module esd_front #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 escape_mode,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_in_last,
   input  logic                 queue_full,
   output logic                 push,
   output esd_pkg::cmd_type     cmd
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic                   seen_first_ff, seen_first_in;
   logic                   esc_pending_ff, esc_pending_in;
   logic [1:0]             hex_phase_ff, hex_phase_in;
   logic [7:0]             hex_first_ff, hex_first_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic                   accept;
   logic [1:0]             n_bytes;
   logic [7:0]             byte0;
   logic [7:0]             byte1;
   logic [1:0]             plain_n;
   logic [7:0]             plain_b0;
   logic                   plain_esc;
   logic [COUNT_WIDTH:0]   count_sum;
   logic [COUNT_WIDTH-1:0] count_next;
   logic [COUNT_WIDTH+15:0] count_ext;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // ordinary byte outside any escape
   always_comb begin
      plain_n   = 2'd1;
      plain_b0  = req_in_byte;
      plain_esc = 1'b0;
      if (req_in_byte == esd_pkg::CHAR_BSLASH) begin
         plain_b0 = 8'h00;
         if (req_in_last) begin
            plain_n = 2'd1;
         end else begin
            plain_n   = 2'd0;
            plain_esc = 1'b1;
         end
      end
   end

   always_comb begin
      n_bytes        = 2'd0;
      byte0          = 8'h00;
      byte1          = 8'h00;
      seen_first_in  = seen_first_ff;
      esc_pending_in = esc_pending_ff;
      hex_phase_in   = hex_phase_ff;
      hex_first_in   = hex_first_ff;
      if (!seen_first_ff) begin
         seen_first_in = 1'b1;
      end else if (hex_phase_ff == esd_pkg::HEX_FIRST) begin
         if (req_in_last) begin
            hex_phase_in   = esd_pkg::HEX_IDLE;
            n_bytes        = plain_n;
            byte0          = plain_b0;
            esc_pending_in = plain_esc;
         end else begin
            hex_first_in = req_in_byte;
            hex_phase_in = esd_pkg::HEX_SECOND;
         end
      end else if (hex_phase_ff == esd_pkg::HEX_SECOND) begin
         n_bytes      = 2'd1;
         byte0        = esd_pkg::hex_pair(hex_first_ff, req_in_byte);
         hex_phase_in = esd_pkg::HEX_IDLE;
      end else if (esc_pending_ff) begin
         esc_pending_in = 1'b0;
         n_bytes        = 2'd1;
         case (req_in_byte)
            esd_pkg::CHAR_LOW_R:  byte0 = esd_pkg::CHAR_CR;
            esd_pkg::CHAR_LOW_N:  byte0 = esd_pkg::CHAR_LF;
            esd_pkg::CHAR_LOW_T:  byte0 = esd_pkg::CHAR_TAB;
            esd_pkg::CHAR_LOW_E:  byte0 = esd_pkg::CHAR_ESC;
            esd_pkg::CHAR_LOW_B:  byte0 = esd_pkg::CHAR_BS;
            esd_pkg::CHAR_LOW_A:  byte0 = esd_pkg::CHAR_BEL;
            esd_pkg::CHAR_BSLASH: byte0 = esd_pkg::CHAR_BSLASH;
            esd_pkg::CHAR_QUOTE:  byte0 = esd_pkg::CHAR_QUOTE;
            esd_pkg::CHAR_LOW_X: begin
               n_bytes = 2'd0;
               if (!req_in_last) begin
                  hex_phase_in = esd_pkg::HEX_FIRST;
               end
            end
            default: begin
               // digits always keep the backslash, other codes per mode
               if ((req_in_byte inside {[8'h30:8'h39]}) || escape_mode) begin
                  n_bytes = 2'd2;
                  byte0   = esd_pkg::CHAR_BSLASH;
                  byte1   = req_in_byte;
               end else begin
                  byte0 = req_in_byte;
               end
            end
         endcase
      end else begin
         n_bytes        = plain_n;
         byte0          = plain_b0;
         esc_pending_in = plain_esc;
      end
      if (req_in_last) begin
         seen_first_in  = 1'b0;
         esc_pending_in = 1'b0;
         hex_phase_in   = esd_pkg::HEX_IDLE;
         hex_first_in   = 8'h00;
      end
   end

   // saturating byte counter
   assign count_sum  = {1'b0, count_ff} + {{(COUNT_WIDTH-1){1'b0}}, n_bytes};
   assign count_next = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                       : count_sum[COUNT_WIDTH-1:0];
   assign count_in   = req_in_last ? {COUNT_WIDTH{1'b0}} : count_next;
   assign count_ext  = {16'h0000, count_next};

   always_comb begin
      cmd.n_bytes = n_bytes;
      cmd.byte0   = byte0;
      cmd.byte1   = byte1;
      cmd.is_end  = req_in_last;
      cmd.length  = (count_ext > (COUNT_WIDTH + 16)'(16'hFFFF)) ? 16'hFFFF
                                                                 : count_ext[15:0];
   end

   assign push = accept && ((n_bytes != 2'd0) || req_in_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_first_ff  <= 1'b0;
         esc_pending_ff <= 1'b0;
         hex_phase_ff   <= esd_pkg::HEX_IDLE;
         hex_first_ff   <= 8'h00;
         count_ff       <= {COUNT_WIDTH{1'b0}};
      end else if (accept) begin
         seen_first_ff  <= seen_first_in;
         esc_pending_ff <= esc_pending_in;
         hex_phase_ff   <= hex_phase_in;
         hex_first_ff   <= hex_first_in;
         count_ff       <= count_in;
      end
   end

endmodule

[hw/rtl/esd_queue.sv]
// small command queue between the front and back ends
module esd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  esd_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output esd_pkg::cmd_type head
);

   esd_pkg::cmd_type                      entry_ff [esd_pkg::QUEUE_DEPTH];
   logic [esd_pkg::QPTR_WIDTH-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [esd_pkg::QPTR_WIDTH-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [esd_pkg::QCNT_WIDTH-1:0]        count_ff, count_in;
   logic                                  do_push;
   logic                                  do_pop;

   assign full    = (count_ff == esd_pkg::QCNT_WIDTH'(esd_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/esd_back.sv]
// back end: unrolls queued commands into response items through an output register
module esd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  esd_pkg::cmd_type head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_is_end,
   output logic [15:0]      rsp_out_length
);

   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        end_ff, end_in;
   logic [15:0] length_ff, length_in;
   logic [1:0]  idx_ff, idx_in;

   logic        load;
   logic        take;
   logic [1:0]  pieces;
   logic        last_piece;
   logic        byte_piece;

   assign load       = !valid_ff || rsp_ready;
   assign take       = load && !empty;
   assign pieces     = head.n_bytes + {1'b0, head.is_end};
   assign last_piece = ((idx_ff + 2'd1) == pieces);
   assign byte_piece = (idx_ff < head.n_bytes);
   assign pop        = take && last_piece;

   always_comb begin
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      end_in    = end_ff;
      length_in = length_ff;
      idx_in    = idx_ff;
      if (take) begin
         valid_in = 1'b1;
         idx_in   = last_piece ? 2'd0 : idx_ff + 2'd1;
         if (byte_piece) begin
            byte_in   = idx_ff[0] ? head.byte1 : head.byte0;
            end_in    = 1'b0;
            length_in = 16'h0000;
         end else begin
            byte_in   = 8'h00;
            end_in    = 1'b1;
            length_in = head.length;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      end_ff    <= end_in;
      length_ff <= length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_is_end     = end_ff;
   assign rsp_out_length = length_ff;

endmodule

[hw/rtl/escape_sequence_decoder_unit.sv]
// Escape sequence decoder: takes one string per packet of request bytes (last byte
// flagged), drops the first byte, decodes backslash escapes and closes every string
// with an end item carrying the saturated decoded length. A request is accepted every
// cycle while the four-entry command queue between the classifier and the output
// stage has room; the output stage delivers one response item per cycle while
// rsp_ready is high, so requests that expand to two or three items (escape kept
// with its backslash, end of string) hold the output longer; the queue absorbs this. The
// single register escape_mode sits at byte address 0; write it only while idle.
module escape_sequence_decoder_unit #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_end,
   output logic [15:0] rsp_out_length,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic             escape_mode_ff, escape_mode_in;
   logic             csr_write;
   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_empty;
   esd_pkg::cmd_type push_cmd;
   esd_pkg::cmd_type head_cmd;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign escape_mode_in = (csr_write && csr_paddr[2] == esd_pkg::REG_ESCAPE_MODE)
                           ? csr_pwdata[0] : escape_mode_ff;
   assign csr_prdata = (csr_paddr[2] == esd_pkg::REG_ESCAPE_MODE)
                       ? {31'h0, escape_mode_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_mode_ff <= 1'b0;
      end else begin
         escape_mode_ff <= escape_mode_in;
      end
   end

   esd_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .escape_mode (escape_mode_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .queue_full  (queue_full),
      .push        (push),
      .cmd         (push_cmd)
   );

   esd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head     (head_cmd)
   );

   esd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .empty          (queue_empty),
      .head           (head_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_end     (rsp_is_end),
      .rsp_out_length (rsp_out_length)
   );

endmodule

[sim/tb_top.sv]
// self-checking testbench for the escape sequence decoder unit
`timescale 1ns / 100ps

module tb_top;

   localparam int          STALL_LIMIT   = 2000;
   localparam int          DRAIN_CYCLES  = 16;
   localparam int          REPORT_LIMIT  = 40;
   localparam int          RANDOM_ITEMS  = 145;
   localparam logic [2:0]  ESC_MODE_ADDR = {esd_pkg::REG_ESCAPE_MODE, 2'b00};
   localparam logic [7:0]  DIGIT_ZERO    = 8'h30;
   localparam logic [7:0]  DIGIT_NINE    = 8'h39;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_end;
      logic [15:0] out_length;
   } decoded_item_type;

   class decode_checker;
      decoded_item_type expected_items[$];
      logic          escape_mode;
      bit            seen_first;
      bit            escape_pending;
      logic [1:0]    hex_phase;
      logic [7:0]    hex_first_char;
      logic [15:0]   byte_count;
      int            mismatches;

      function new();
         escape_mode = 1'b0;
         mismatches  = 0;
         clear_string();
      endfunction

      function void clear_string();
         seen_first     = 0;
         escape_pending = 0;
         hex_phase      = esd_pkg::HEX_IDLE;
         hex_first_char = 8'h00;
         byte_count     = '0;
      endfunction

      function void emit(logic [7:0] b);
         decoded_item_type item;
         item.out_byte   = b;
         item.is_end     = 1'b0;
         item.out_length = 16'h0000;
         expected_items.push_back(item);
         if (byte_count != 16'hFFFF) byte_count++;
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
      endfunction

      function int hex_digit_value(logic [7:0] c);
         if (c >= DIGIT_ZERO && c <= DIGIT_NINE) return c - DIGIT_ZERO;
         if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
         if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
         return -1;
      endfunction

      // two characters parsed like strtol base 16, wrapped to a byte
      function logic [7:0] strtol_pair(logic [7:0] c0, logic [7:0] c1);
         logic [7:0] chars[2];
         int         pos;
         int         d;
         logic [7:0] acc;
         bit         neg;
         chars[0] = c0;
         chars[1] = c1;
         pos = 0;
         acc = 8'h00;
         neg = 0;
         while (pos < 2 && is_blank(chars[pos])) pos++;
         if (pos < 2 && (chars[pos] == esd_pkg::CHAR_PLUS ||
                         chars[pos] == esd_pkg::CHAR_MINUS)) begin
            neg = chars[pos] == esd_pkg::CHAR_MINUS;
            pos++;
         end
         while (pos < 2) begin
            d = hex_digit_value(chars[pos]);
            if (d < 0) break;
            acc = {acc[3:0], 4'(d)};
            pos++;
         end
         return neg ? 8'h00 - acc : acc;
      endfunction

      function void take_plain(logic [7:0] b, logic last);
         if (b == esd_pkg::CHAR_BSLASH) begin
            if (last) emit(8'h00);
            else escape_pending = 1;
         end else begin
            emit(b);
         end
      endfunction

      function void take_escaped(logic [7:0] b, logic last);
         case (b)
            esd_pkg::CHAR_LOW_R:  emit(esd_pkg::CHAR_CR);
            esd_pkg::CHAR_LOW_N:  emit(esd_pkg::CHAR_LF);
            esd_pkg::CHAR_LOW_T:  emit(esd_pkg::CHAR_TAB);
            esd_pkg::CHAR_LOW_E:  emit(esd_pkg::CHAR_ESC);
            esd_pkg::CHAR_LOW_B:  emit(esd_pkg::CHAR_BS);
            esd_pkg::CHAR_LOW_A:  emit(esd_pkg::CHAR_BEL);
            esd_pkg::CHAR_BSLASH: emit(esd_pkg::CHAR_BSLASH);
            esd_pkg::CHAR_QUOTE:  emit(esd_pkg::CHAR_QUOTE);
            esd_pkg::CHAR_LOW_X: begin
               if (!last) hex_phase = esd_pkg::HEX_FIRST;
            end
            default: begin
               if ((b >= DIGIT_ZERO && b <= DIGIT_NINE) || escape_mode) begin
                  emit(esd_pkg::CHAR_BSLASH);
                  emit(b);
               end else begin
                  emit(b);
               end
            end
         endcase
      endfunction

      function void note_request(logic [7:0] b, logic last);
         decoded_item_type item;
         if (!seen_first) begin
            seen_first = 1;
         end else if (hex_phase == esd_pkg::HEX_FIRST) begin
            // string ends right after the x: the character is taken as plain text
            if (last) begin
               hex_phase = esd_pkg::HEX_IDLE;
               take_plain(b, last);
            end else begin
               hex_first_char = b;
               hex_phase      = esd_pkg::HEX_SECOND;
            end
         end else if (hex_phase == esd_pkg::HEX_SECOND) begin
            emit(strtol_pair(hex_first_char, b));
            hex_phase = esd_pkg::HEX_IDLE;
         end else if (escape_pending) begin
            escape_pending = 0;
            take_escaped(b, last);
         end else begin
            take_plain(b, last);
         end
         if (last) begin
            item.out_byte   = 8'h00;
            item.is_end     = 1'b1;
            item.out_length = byte_count;
            expected_items.push_back(item);
            clear_string();
         end
      endfunction

      function void check_item(logic [7:0] ob, logic ie, logic [15:0] ol);
         decoded_item_type exp_item;
         if (expected_items.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $error("unexpected response: out_byte %0h is_end %0b out_length %0d",
                      ob, ie, ol);
            return;
         end
         exp_item = expected_items.pop_front();
         if (ob !== exp_item.out_byte) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $error("out_byte: expected %0h, got %0h", exp_item.out_byte, ob);
         end
         if (ie !== exp_item.is_end) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $error("is_end: expected %0b, got %0b", exp_item.is_end, ie);
         end
         if (ol !== exp_item.out_length) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $error("out_length: expected %0d, got %0d", exp_item.out_length, ol);
         end
      endfunction

      function int pending();
         return expected_items.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        req_in_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_end;
   logic [15:0] rsp_out_length;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   decode_checker decoder_model = new();
   bit            no_idle = 0;
   int            items_sent = 0;
   int            idle_cycles = 0;

   escape_sequence_decoder_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_end     (rsp_is_end),
      .rsp_out_length (rsp_out_length),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 70);
   endfunction

   function automatic logic [7:0] known_escape(int idx);
      case (idx)
         0: return esd_pkg::CHAR_LOW_R;
         1: return esd_pkg::CHAR_LOW_N;
         2: return esd_pkg::CHAR_LOW_T;
         3: return esd_pkg::CHAR_LOW_E;
         4: return esd_pkg::CHAR_LOW_B;
         5: return esd_pkg::CHAR_LOW_A;
         6: return esd_pkg::CHAR_BSLASH;
         default: return esd_pkg::CHAR_QUOTE;
      endcase
   endfunction

   // characters that steer the hex parse through blanks, signs and digits
   function automatic logic [7:0] hex_candidate();
      int sel;
      case ($urandom_range(0, 5))
         0: begin
            sel = $urandom_range(0, 5);
            return sel == 5 ? 8'h20 : 8'h09 + 8'(sel);
         end
         1: return $urandom_range(0, 1) ? esd_pkg::CHAR_PLUS : esd_pkg::CHAR_MINUS;
         2, 3: begin
            sel = $urandom_range(0, 21);
            if (sel < 10) return DIGIT_ZERO + 8'(sel);
            if (sel < 16) return 8'h61 + 8'(sel - 10);
            return 8'h41 + 8'(sel - 16);
         end
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic make_text(output logic [7:0] text[$]);
      int tokens;
      text = {};
      text.push_back(8'($urandom_range(1, 255)));
      if ($urandom_range(0, 9) == 0) begin
         // noise
         repeat ($urandom_range(0, 8)) text.push_back(8'($urandom_range(1, 255)));
         return;
      end
      tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
      for (int i = 0; i < tokens; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: text.push_back(8'($urandom_range(1, 255)));
            3, 4: begin
               text.push_back(esd_pkg::CHAR_BSLASH);
               text.push_back(known_escape($urandom_range(0, 7)));
            end
            5: begin
               text.push_back(esd_pkg::CHAR_BSLASH);
               text.push_back(8'($urandom_range(DIGIT_ZERO, DIGIT_NINE)));
            end
            6: begin
               text.push_back(esd_pkg::CHAR_BSLASH);
               text.push_back(8'($urandom_range(1, 255)));
            end
            7, 8: begin
               text.push_back(esd_pkg::CHAR_BSLASH);
               text.push_back(esd_pkg::CHAR_LOW_X);
               text.push_back(hex_candidate());
               text.push_back(hex_candidate());
            end
            default: begin
               // cut short: lone backslash or truncated hex escape at the end
               text.push_back(esd_pkg::CHAR_BSLASH);
               if ($urandom_range(0, 2) != 0) text.push_back(esd_pkg::CHAR_LOW_X);
               if ($urandom_range(0, 1) != 0) text.push_back(hex_candidate());
               return;
            end
         endcase
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      @(negedge clock);
      while (gap > 0) begin
         req_valid = 1'b0;
         gap--;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_in_byte = b;
      req_in_last = last;
      do @(posedge clock); while (!req_ready);
      decoder_model.note_request(b, last);
      items_sent++;
   endtask

   task automatic send_text(input logic [7:0] text[$]);
      for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (decoder_model.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_escape_mode(input logic value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = ESC_MODE_ADDR;
      csr_pwdata  = {31'b0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      decoder_model.escape_mode = value;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // response side: sample at the edge, check and drive ready at the falling edge
   initial begin
      int         stall_left;
      bit         fire;
      logic [7:0]  got_byte;
      logic        got_end;
      logic [15:0] got_length;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         fire       = !reset && rsp_valid && rsp_ready;
         got_byte   = rsp_out_byte;
         got_end    = rsp_is_end;
         got_length = rsp_out_length;
         @(negedge clock);
         if (fire) decoder_model.check_item(got_byte, got_end, got_length);
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (!no_idle && $urandom_range(0, 4) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                   (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [7:0] text[$];
      int         start;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'h00;
      req_in_last = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_escape_mode(1'b0);

      // single-byte string: end item alone
      text = {8'hFF};
      send_text(text);
      // every known escape, digit escape, unknown escape, signed hex, trailing backslash
      text = {8'h01,
              esd_pkg::CHAR_BSLASH, esd_pkg::CHAR_LOW_R,
              esd_pkg::CHAR_BSLASH, esd_pkg::CHAR_LOW_N,
              esd_pkg::CHAR_BSLASH, esd_pkg::CHAR_LOW_T,
              esd_pkg::CHAR_BSLASH, esd_pkg::CHAR_LOW_E,
              esd_pkg::CHAR_BSLASH, esd_pkg::CHAR_LOW_B,
              esd_pkg::CHAR_BSLASH, esd_pkg::CHAR_LOW_A,
              esd_pkg::CHAR_BSLASH, esd_pkg::CHAR_BSLASH,
              esd_pkg::CHAR_BSLASH, esd_pkg::CHAR_QUOTE,
              esd_pkg::CHAR_BSLASH, 8'h37,
              esd_pkg::CHAR_BSLASH, 8'h7A,
              esd_pkg::CHAR_BSLASH, esd_pkg::CHAR_LOW_X, esd_pkg::CHAR_MINUS, 8'h46,
              8'h80,
              esd_pkg::CHAR_BSLASH};
      send_text(text);
      // string ends on the x
      text = {8'h41, esd_pkg::CHAR_BSLASH, esd_pkg::CHAR_LOW_X};
      send_text(text);
      // string ends one past the x, with a zero byte taken as plain text
      text = {8'h42, esd_pkg::CHAR_BSLASH, esd_pkg::CHAR_LOW_X, 8'h00};
      send_text(text);

      settle();
      set_escape_mode(1'b1);
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         no_idle = $urandom_range(0, 7) == 0;
         make_text(text);
         send_text(text);
      end

      settle();
      set_escape_mode(1'b0);
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         no_idle = $urandom_range(0, 7) == 0;
         make_text(text);
         send_text(text);
      end

      settle();
      if (decoder_model.mismatches == 0 && decoder_model.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/esd_pkg.sv
hw/rtl/esd_front.sv
hw/rtl/esd_queue.sv
hw/rtl/esd_back.sv
hw/rtl/escape_sequence_decoder_unit.sv
sim/tb_top.sv
